// ===== rtl/gwwlb_pkg.sv =====
// ----------------------------------------------------------------------------
// Greedy word-wrap line breaker: shared types and constants
// Result record, register indexes and character codes used by the block.
// ----------------------------------------------------------------------------
package gwwlb_pkg;

  localparam logic [7:0] CODE_CR = 8'h0D;
  localparam logic [7:0] CODE_SP = 8'h20;

  localparam logic REG_WRAP_WIDTH  = 1'b0;
  localparam logic REG_RETURN_ONLY = 1'b1;

  typedef logic [1:0] res_cnt_t;

  typedef struct packed {
    logic [12:0] line_start;
    logic [7:0]  line_number;
    logic        summary_item;
    logic [8:0]  line_count;
    logic        overflow;
    logic        last_of_run;
  } result_t;

endpackage

// ===== rtl/gwwlb_core.sv =====
// ----------------------------------------------------------------------------
// Greedy word-wrap line breaker: text state and break decision
// Holds the configuration and text state and works out, for one character
// or end-of-text transaction, the line starts and summary it produces.
// ----------------------------------------------------------------------------
module gwwlb_core #(
  parameter int TEXT_MAX  = 4096,
  parameter int MAX_LINES = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [11:0]        cfg_wdata_i,
  input  logic [7:0]         ch_i,
  input  logic               end_of_text_i,
  input  logic               step_i,
  output gwwlb_pkg::result_t res0_o,
  output gwwlb_pkg::result_t res1_o,
  output gwwlb_pkg::res_cnt_t res_cnt_o
);
  import gwwlb_pkg::*;

  localparam int PW = $clog2(TEXT_MAX + 1);
  localparam int LW = $clog2(MAX_LINES + 1);
  localparam int CW = (PW > 12) ? PW : 12;

  logic [11:0]   wrap_width_q;
  logic          return_only_q;

  logic [PW-1:0] pos_q, pos_d;
  logic [PW-1:0] cls_q, cls_d;
  logic [PW-1:0] lsp_q, lsp_d;
  logic          lsv_q, lsv_d;
  logic [LW-1:0] lines_q, lines_d;
  logic          started_q, started_d;
  logic          ovf_q, ovf_d;

  logic [LW-1:0] lines_1;
  logic          wrap_on;
  logic [CW-1:0] line_len;
  logic [CW-1:0] sdist;
  logic          wrap_hit;
  logic          soft_ok;
  logic [PW-1:0] brk;
  logic          rec_req;
  logic [PW-1:0] rec_start;
  logic          sec_vld;
  result_t       line0;
  result_t       second;

  function automatic logic [12:0] to_start(logic [PW-1:0] v);
    logic [PW+12:0] w;
    w = {13'b0, v};
    return w[12:0];
  endfunction

  function automatic logic [7:0] to_num(logic [LW-1:0] v);
    logic [LW+7:0] w;
    w = {8'b0, v};
    return w[7:0];
  endfunction

  function automatic logic [8:0] to_cnt(logic [LW-1:0] v);
    logic [LW+8:0] w;
    w = {9'b0, v};
    return w[8:0];
  endfunction

  always_comb begin
    pos_d     = pos_q;
    cls_d     = cls_q;
    lsp_d     = lsp_q;
    lsv_d     = lsv_q;
    lines_d   = lines_q;
    started_d = 1'b1;
    ovf_d     = ovf_q;
    lines_1   = started_q ? lines_q : lines_q + 1'b1;
    wrap_on   = !return_only_q && (wrap_width_q != 12'd0);
    line_len  = CW'(pos_q) - CW'(cls_q);
    sdist     = CW'(pos_q) - CW'(lsp_q) - CW'(1);
    wrap_hit  = wrap_on && (pos_q >= cls_q) && (line_len >= CW'(wrap_width_q));
    soft_ok   = lsv_q && (lsp_q < pos_q) && (sdist < CW'(wrap_width_q));
    brk       = soft_ok ? lsp_q + 1'b1 : pos_q;
    rec_req   = 1'b0;
    rec_start = '0;
    sec_vld   = 1'b0;

    if (!started_q) begin
      cls_d   = '0;
      lines_d = lines_1;
    end

    line0.line_start   = '0;
    line0.line_number  = '0;
    line0.summary_item = 1'b0;
    line0.line_count   = '0;
    line0.overflow     = ovf_q;
    line0.last_of_run  = 1'b0;
    second             = line0;

    if (end_of_text_i) begin
      sec_vld             = 1'b1;
      second.summary_item = 1'b1;
      second.line_count   = to_cnt(lines_1);
      pos_d     = '0;
      cls_d     = '0;
      lsp_d     = '0;
      lsv_d     = 1'b0;
      lines_d   = '0;
      started_d = 1'b0;
      ovf_d     = 1'b0;
    end else if (pos_q >= PW'(TEXT_MAX)) begin
      ovf_d = 1'b1;
    end else begin
      if (ch_i == CODE_CR) begin
        rec_req   = 1'b1;
        rec_start = pos_q + 1'b1;
        cls_d     = pos_q + 1'b1;
        lsv_d     = 1'b0;
      end else begin
        if (wrap_hit) begin
          rec_req   = 1'b1;
          rec_start = brk;
          cls_d     = brk;
          lsv_d     = 1'b0;
        end
        if (ch_i == CODE_SP) begin
          lsp_d = pos_q;
          lsv_d = 1'b1;
        end
      end
      pos_d = pos_q + 1'b1;
      if (rec_req) begin
        if (lines_1 >= LW'(MAX_LINES)) begin
          ovf_d = 1'b1;
        end else begin
          sec_vld            = 1'b1;
          second.line_start  = to_start(rec_start);
          second.line_number = to_num(lines_1);
          lines_d            = lines_1 + 1'b1;
        end
      end
    end

    second.last_of_run = 1'b1;
    if (!started_q) begin
      res0_o             = line0;
      res0_o.last_of_run = !sec_vld;
      res1_o             = second;
      res_cnt_o          = sec_vld ? res_cnt_t'(2) : res_cnt_t'(1);
    end else begin
      res0_o    = second;
      res1_o    = second;
      res_cnt_o = sec_vld ? res_cnt_t'(1) : res_cnt_t'(0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wrap_width_q  <= '0;
      return_only_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_WRAP_WIDTH:  wrap_width_q  <= cfg_wdata_i;
        REG_RETURN_ONLY: return_only_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      cls_q     <= '0;
      lsp_q     <= '0;
      lsv_q     <= 1'b0;
      lines_q   <= '0;
      started_q <= 1'b0;
      ovf_q     <= 1'b0;
    end else if (step_i) begin
      pos_q     <= pos_d;
      cls_q     <= cls_d;
      lsp_q     <= lsp_d;
      lsv_q     <= lsv_d;
      lines_q   <= lines_d;
      started_q <= started_d;
      ovf_q     <= ovf_d;
    end
  end

endmodule

// ===== rtl/gwwlb_out_buf.sv =====
// ----------------------------------------------------------------------------
// Greedy word-wrap line breaker: result buffer
// Holds the one or two results of a transaction and hands them out in order.
// ----------------------------------------------------------------------------
module gwwlb_out_buf (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  gwwlb_pkg::res_cnt_t cnt_i,
  input  gwwlb_pkg::result_t  res0_i,
  input  gwwlb_pkg::result_t  res1_i,
  output logic                load_ok_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output gwwlb_pkg::result_t  res_o
);
  import gwwlb_pkg::*;

  res_cnt_t cnt_q;
  result_t  res0_q;
  result_t  res1_q;
  logic     pop;

  assign out_valid_o = (cnt_q != res_cnt_t'(0));
  assign pop         = out_valid_o && out_ready_i;
  assign load_ok_o   = (cnt_q == res_cnt_t'(0)) || ((cnt_q == res_cnt_t'(1)) && out_ready_i);
  assign res_o       = res0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (load_i) begin
      cnt_q <= cnt_i;
    end else if (pop) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res0_q <= res0_i;
      res1_q <= res1_i;
    end else if (pop) begin
      res0_q <= res1_q;
    end
  end

endmodule

// ===== rtl/greedy_word_wrap_line_breaker.sv =====
// ----------------------------------------------------------------------------
// Greedy word-wrap line breaker
// Takes a text one character per transaction and reports the start offset of
// every display line up to MAX_LINES, breaking at carriage returns and, when
// wrapping is on, after the last space or at the character that does not fit.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake               Payload
//  in       input      in_valid_i/in_ready_o   ch_i, end_of_text_i
//  out      output     out_valid_o/out_ready_i line_start_o .. last_of_run_o
//  cfg      input      cfg_we_i                cfg_idx_i, cfg_wdata_i
//
// An input transaction is registered, then decided, and its one or two results
// are written to the result buffer. Transactions with at most one result flow
// at one per cycle while the output is ready; the first of a text may give two
// results, and a following transaction with results waits until the second is
// taken. Reset clears all text state and the configuration. A stalled output
// backs up through the result buffer and the input register without loss.
// ----------------------------------------------------------------------------
module greedy_word_wrap_line_breaker #(
  parameter int TEXT_MAX  = 4096,
  parameter int MAX_LINES = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [11:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  ch_i,
  input  logic        end_of_text_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [12:0] line_start_o,
  output logic [7:0]  line_number_o,
  output logic        summary_item_o,
  output logic [8:0]  line_count_o,
  output logic        overflow_o,
  output logic        last_of_run_o
);
  import gwwlb_pkg::*;

  logic     in_vld_q;
  logic     in_vld_d;
  logic [7:0] ch_q;
  logic     eot_q;
  logic     accept;
  logic     advance;
  logic     load_ok;
  res_cnt_t res_cnt;
  result_t  res0;
  result_t  res1;
  result_t  res_out;

  assign advance    = in_vld_q && ((res_cnt == res_cnt_t'(0)) || load_ok);
  assign in_ready_o = !in_vld_q || advance;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    in_vld_d = in_vld_q;
    if (accept) begin
      in_vld_d = 1'b1;
    end else if (advance) begin
      in_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ch_q  <= ch_i;
      eot_q <= end_of_text_i;
    end
  end

  gwwlb_core #(
    .TEXT_MAX  (TEXT_MAX),
    .MAX_LINES (MAX_LINES)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .ch_i          (ch_q),
    .end_of_text_i (eot_q),
    .step_i        (advance),
    .res0_o        (res0),
    .res1_o        (res1),
    .res_cnt_o     (res_cnt)
  );

  gwwlb_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance && (res_cnt != res_cnt_t'(0))),
    .cnt_i       (res_cnt),
    .res0_i      (res0),
    .res1_i      (res1),
    .load_ok_o   (load_ok),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res_out)
  );

  assign line_start_o   = res_out.line_start;
  assign line_number_o  = res_out.line_number;
  assign summary_item_o = res_out.summary_item;
  assign line_count_o   = res_out.line_count;
  assign overflow_o     = res_out.overflow;
  assign last_of_run_o  = res_out.last_of_run;

endmodule

// ===== tb/line_break_tracker_pkg.sv =====
// ----------------------------------------------------------------------------
// Line break tracker for the greedy word-wrap line breaker
// Keeps its own copy of the text state and the two registers, works out
// the line starts and text summaries that each accepted input transaction
// should produce, and checks every result transaction against the oldest
// outstanding one, field by field.
// ----------------------------------------------------------------------------
package line_break_tracker_pkg;

  import gwwlb_pkg::*;

  localparam int TEXT_MAX  = 4096;
  localparam int MAX_LINES = 256;

  class line_break_tracker;

    logic [11:0] wrap_width;
    logic        return_only;

    logic [12:0] char_pos;
    logic [12:0] line_begin;
    logic [12:0] space_pos;
    logic        space_seen;
    logic [8:0]  lines_done;
    logic        text_open;
    logic        overflow_seen;

    result_t     expected_lines[$];
    result_t     step_lines[$];
    int          mismatches;

    function new();
      wrap_width  = '0;
      return_only = 1'b0;
      mismatches  = 0;
      clear_text();
    endfunction

    function void clear_text();
      char_pos      = '0;
      line_begin    = '0;
      space_pos     = '0;
      space_seen    = 1'b0;
      lines_done    = '0;
      text_open     = 1'b0;
      overflow_seen = 1'b0;
    endfunction

    function void set_register(logic idx, logic [11:0] data);
      if (idx == REG_WRAP_WIDTH) begin
        wrap_width = data;
      end else begin
        return_only = data[0];
      end
    endfunction

    function void add_line(int start);
      result_t r;
      if (int'(lines_done) >= MAX_LINES) begin
        overflow_seen = 1'b1;
        return;
      end
      r             = '0;
      r.line_start  = 13'(start);
      r.line_number = lines_done[7:0];
      r.overflow    = overflow_seen;
      step_lines.push_back(r);
      lines_done++;
    endfunction

    function void note_input(logic [7:0] c, logic eot);
      result_t r;
      int      i;
      int      brk;
      bit      wrap_on;
      step_lines.delete();
      if (!text_open) begin
        text_open  = 1'b1;
        line_begin = '0;
        add_line(0);
      end
      if (eot) begin
        r              = '0;
        r.summary_item = 1'b1;
        r.line_count   = lines_done;
        r.overflow     = overflow_seen;
        step_lines.push_back(r);
        clear_text();
      end else if (int'(char_pos) >= TEXT_MAX) begin
        overflow_seen = 1'b1;
      end else begin
        i       = int'(char_pos);
        wrap_on = !return_only && (wrap_width != 0);
        if (c == CODE_CR) begin
          add_line(i + 1);
          line_begin = 13'(i + 1);
          space_seen = 1'b0;
        end else begin
          if (wrap_on && i >= int'(line_begin) &&
              i - int'(line_begin) >= int'(wrap_width)) begin
            brk = i;
            if (space_seen && int'(space_pos) + 1 <= i &&
                i - (int'(space_pos) + 1) < int'(wrap_width)) begin
              brk = int'(space_pos) + 1;
            end
            add_line(brk);
            line_begin = 13'(brk);
            space_seen = 1'b0;
          end
          if (c == CODE_SP) begin
            space_pos  = 13'(i);
            space_seen = 1'b1;
          end
        end
        char_pos = 13'(i + 1);
      end
      if (step_lines.size() > 0) begin
        r             = step_lines.pop_back();
        r.last_of_run = 1'b1;
        step_lines.push_back(r);
      end
      foreach (step_lines[k]) begin
        expected_lines.push_back(step_lines[k]);
      end
    endfunction

    function void compare_field(string name, int want, int got);
      if (want != got) begin
        $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_lines.size() == 0) begin
        $display("%0t: result expected none, actual line_start %0d line_number %0d summary %0d",
                 $time, got.line_start, got.line_number, got.summary_item);
        mismatches++;
        return;
      end
      want = expected_lines.pop_front();
      compare_field("line_start", want.line_start, got.line_start);
      compare_field("line_number", want.line_number, got.line_number);
      compare_field("summary_item", want.summary_item, got.summary_item);
      compare_field("line_count", want.line_count, got.line_count);
      compare_field("overflow", want.overflow, got.overflow);
      compare_field("last_of_run", want.last_of_run, got.last_of_run);
    endfunction

  endclass

endpackage

// ===== tb/greedy_word_wrap_line_breaker_test.sv =====
// ----------------------------------------------------------------------------
// Greedy word-wrap line breaker testbench
// Drives texts of carriage returns, spaces and arbitrary bytes through the
// block under a range of wrap widths and modes, with random gaps on both
// channels, and checks every line start and text summary against the line
// break tracker. Covers empty texts, soft and hard breaks, width changes in
// the middle of a text and a full line table.
// ----------------------------------------------------------------------------
module greedy_word_wrap_line_breaker_test;

  import gwwlb_pkg::*;
  import line_break_tracker_pkg::*;

  localparam int IDLE_LIMIT    = 5000;
  localparam int SETTLE_CYCLES = 8;
  localparam int ITEM_COUNT    = 1400;

  typedef enum int {
    STYLE_PROSE,
    STYLE_ANY,
    STYLE_UNBROKEN
  } text_style_e;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_idx_i;
  logic [11:0] cfg_wdata_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  ch_i;
  logic        end_of_text_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [12:0] line_start_o;
  logic [7:0]  line_number_o;
  logic        summary_item_o;
  logic [8:0]  line_count_o;
  logic        overflow_o;
  logic        last_of_run_o;

  line_break_tracker tracker = new();
  int                idle_cycles = 0;
  int                items_sent = 0;
  bit                quiet = 1'b0;

  greedy_word_wrap_line_breaker #(
    .TEXT_MAX (TEXT_MAX),
    .MAX_LINES(MAX_LINES)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .ch_i          (ch_i),
    .end_of_text_i (end_of_text_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .line_start_o  (line_start_o),
    .line_number_o (line_number_o),
    .summary_item_o(summary_item_o),
    .line_count_o  (line_count_o),
    .overflow_o    (overflow_o),
    .last_of_run_o (last_of_run_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] pick_char(text_style_e style);
    int r;
    r = $urandom_range(0, 99);
    case (style)
      STYLE_ANY: begin
        return 8'($urandom_range(0, 255));
      end
      STYLE_UNBROKEN: begin
        return 8'(8'h61 + $urandom_range(0, 25));
      end
      default: begin
        if (r < 70) return 8'(8'h61 + $urandom_range(0, 25));
        if (r < 88) return CODE_SP;
        if (r < 94) return CODE_CR;
        return 8'($urandom_range(0, 255));
      end
    endcase
  endfunction

  function automatic logic [11:0] pick_width();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 12'd0;
    if (r == 1) return 12'd4095;
    if (r == 2) return 12'd1;
    return 12'($urandom_range(1, 16));
  endfunction

  always @(posedge clk_i) begin
    result_t seen;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        tracker.note_input(ch_i, end_of_text_i);
      end
      if (out_valid_o && out_ready_i) begin
        seen = {line_start_o, line_number_o, summary_item_o, line_count_o,
                overflow_o, last_of_run_o};
        tracker.check_result(seen);
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
  end

  initial begin
    int burst;
    int stall;
    out_ready_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      burst = $urandom_range(1, 40);
      out_ready_i <= 1'b1;
      repeat (burst) @(posedge clk_i);
      stall = pick_gap();
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
    end
  end

  initial begin
    do @(posedge clk_i); while (idle_cycles < IDLE_LIMIT);
    $display("Mismatches found");
    $finish;
  end

  task automatic send_item(logic [7:0] c, logic eot);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    ch_i          <= c;
    end_of_text_i <= eot;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic wait_all_lines();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (tracker.expected_lines.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic configure(logic [11:0] width, logic ro_mode);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_WRAP_WIDTH;
    cfg_wdata_i <= width;
    @(posedge clk_i);
    tracker.set_register(REG_WRAP_WIDTH, width);
    cfg_idx_i   <= REG_RETURN_ONLY;
    cfg_wdata_i <= {11'd0, ro_mode};
    @(posedge clk_i);
    tracker.set_register(REG_RETURN_ONLY, {11'd0, ro_mode});
    cfg_we_i    <= 1'b0;
  endtask

  task automatic send_text(int len, text_style_e style, bit close_it);
    for (int k = 0; k < len; k++) begin
      send_item(pick_char(style), 1'b0);
    end
    if (close_it) begin
      send_item(8'($urandom_range(0, 255)), 1'b1);
    end
  endtask

  initial begin
    text_style_e style;
    int          len;
    int          r;
    in_valid_i    <= 1'b0;
    ch_i          <= 8'h00;
    end_of_text_i <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= REG_WRAP_WIDTH;
    cfg_wdata_i   <= 12'd0;
    rst_ni        <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    configure(12'd5, 1'b0);
    send_item(8'hFF, 1'b1);
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(CODE_SP, 1'b0);
    for (int k = 0; k < 6; k++) send_item(8'(8'h61 + k), 1'b0);
    send_item(CODE_CR, 1'b0);
    send_item(CODE_CR, 1'b0);
    send_item(8'h67, 1'b1);
    wait_all_lines();

    configure(12'd1, 1'b0);
    send_item(8'h61, 1'b0);
    send_item(8'h62, 1'b0);
    send_item(CODE_SP, 1'b0);
    send_item(8'h63, 1'b0);
    send_item(8'h00, 1'b1);
    wait_all_lines();

    configure(12'd12, 1'b0);
    send_item(8'h61, 1'b0);
    send_item(CODE_SP, 1'b0);
    for (int k = 0; k < 6; k++) send_item(8'(8'h62 + k), 1'b0);
    wait_all_lines();
    configure(12'd2, 1'b0);
    send_item(8'h69, 1'b0);
    send_item(8'h6A, 1'b1);
    wait_all_lines();

    configure(12'd4095, 1'b1);
    send_item(8'h61, 1'b0);
    send_item(CODE_CR, 1'b0);
    send_item(CODE_SP, 1'b0);
    send_item(8'h62, 1'b1);
    wait_all_lines();

    configure(12'd1, 1'b0);
    send_text(300, STYLE_UNBROKEN, 1'b1);
    wait_all_lines();

    while (items_sent < ITEM_COUNT) begin
      wait_all_lines();
      quiet = ($urandom_range(0, 4) == 0);
      configure(pick_width(), $urandom_range(0, 4) == 0);
      repeat ($urandom_range(1, 4)) begin
        r = $urandom_range(0, 99);
        if (r < 70) style = STYLE_PROSE;
        else if (r < 85) style = STYLE_ANY;
        else style = STYLE_UNBROKEN;
        len = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 40) : $urandom_range(41, 120);
        send_text(len, style, $urandom_range(0, 4) != 0);
        if ($urandom_range(0, 9) == 0) wait_all_lines();
      end
    end
    quiet = 1'b0;
    wait_all_lines();

    if (tracker.mismatches == 0 && tracker.expected_lines.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== greedy_word_wrap_line_breaker.f =====
rtl/gwwlb_pkg.sv
rtl/gwwlb_core.sv
rtl/gwwlb_out_buf.sv
rtl/greedy_word_wrap_line_breaker.sv
tb/line_break_tracker_pkg.sv
tb/greedy_word_wrap_line_breaker_test.sv
